// ===== sv/nalsplit_pkg.sv =====
// Shared types and constants for the Annex B NAL unit splitter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nalsplit_pkg;

  localparam int RES_W  = 32;
  localparam int KIND_W = 5;
  localparam int DEFAULT_OFFSET_BITS = 32;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [31:0] TYPE_MASK_RESET = 32'h0000_1FE2;

  // Register index as decoded from the word address.
  localparam logic [0:0] REG_TYPE_MASK = 1'b0;

  // One result transaction.
  typedef struct packed {
    logic [RES_W-1:0]  offset;
    logic [RES_W-1:0]  size;
    logic [KIND_W-1:0] kind;
    logic              found;
    logic              last_nal;
  } result_t;

  // Everything one input byte produces: a closed unit and/or the buffer end.
  typedef struct packed {
    logic    close_valid;
    result_t close_res;
    logic    end_valid;
    result_t end_res;
  } record_t;

endpackage

`default_nettype wire

// ===== sv/annexb_nal_unit_splitter.sv =====
// Top level of the Annex B NAL unit splitter: configuration register,
// front end, record queue and result sequencer. Depends on nalsplit_pkg.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+---------------------------------
//   input    | in        | push / full          | data_byte, end_of_buffer
//   result   | out       | empty / pop          | nal_offset, nal_size, nal_kind,
//            |           |                      | found, last_nal
//   config   | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// One byte is taken per cycle while the queue is not full; the start code compare
// works on a four byte history plus the incoming byte, so no byte waits on
// another. A byte that closes a unit or ends the buffer writes one record into a
// short queue; the sequencer drains one result per cycle unless a result waits
// unpopped, so a record with a closed unit and the buffer end gives two results.
// full rises only when the queue is full. Reset is synchronous and needs no
// clearing pass; the type mask returns to types 1 and 5 through 12.
`default_nettype none

module annexb_nal_unit_splitter import nalsplit_pkg::*; #(
  parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS,
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transactions
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  // result transactions
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      nal_offset,
  output logic [31:0]      nal_size,
  output logic [4:0]       nal_kind,
  output logic             found,
  output logic             last_nal,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] type_mask;
  logic        in_accept;
  record_t     front_rec;
  record_t     queue_rec;
  logic        rec_push;
  logic        rec_pop;
  logic        rec_empty;
  logic        res_valid;
  result_t     res;

  // Only word address bit 2 selects a register; low bits are byte lanes.
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_TYPE_MASK) ? type_mask : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_mask <= TYPE_MASK_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2:2] == REG_TYPE_MASK)) begin
      type_mask <= pwdata;
    end
  end

  // A byte is accepted whenever the queue has room; bytes that produce no
  // result leave the queue untouched.
  assign in_accept = push && !full;

  nalsplit_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .type_mask     (type_mask),
    .rec           (front_rec),
    .rec_push      (rec_push)
  );

  nalsplit_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (front_rec),
    .rd_en   (rec_pop),
    .rd_data (queue_rec),
    .full    (full),
    .empty   (rec_empty)
  );

  nalsplit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (queue_rec),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // The sequencer's output register is the head of the result queue.
  assign empty      = !res_valid;
  assign nal_offset = res.offset;
  assign nal_size   = res.size;
  assign nal_kind   = res.kind;
  assign found      = res.found;
  assign last_nal   = res.last_nal;

endmodule

`default_nettype wire

// ===== sv/nalsplit_front.sv =====
// Front end: byte history, start code detection and NAL unit tracking.
// Depends on nalsplit_pkg.
`default_nettype none

module nalsplit_front import nalsplit_pkg::*; #(
  parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  input  wire logic [31:0] type_mask,
  output record_t          rec,
  output logic             rec_push
);

  localparam logic [OFFSET_BITS-1:0] ONE   = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] TWO   = OFFSET_BITS'(2);
  localparam logic [OFFSET_BITS-1:0] THREE = OFFSET_BITS'(3);
  localparam logic [OFFSET_BITS-1:0] FOUR  = OFFSET_BITS'(4);
  localparam logic [OFFSET_BITS-1:0] FIVE  = OFFSET_BITS'(5);

  logic [7:0]             hist [4];
  logic [OFFSET_BITS-1:0] pos;
  logic                   unit_open;
  logic [OFFSET_BITS-1:0] open_offset;
  logic [KIND_W-1:0]      open_kind;
  logic [OFFSET_BITS-1:0] earliest;

  logic                   win_ok;
  logic [OFFSET_BITS-1:0] code_pos;
  logic                   hit3;
  logic                   hit4;
  logic [7:0]             hdr;
  logic [KIND_W-1:0]      kind;
  logic                   code_ok;
  logic [OFFSET_BITS-1:0] hdr_pos;
  logic [OFFSET_BITS-1:0] earliest_next;
  logic [OFFSET_BITS-1:0] close_size;
  logic [OFFSET_BITS-1:0] end_size;

  always_comb begin
    // A code starting at pos-4 is examined once the fifth byte is here.
    win_ok   = |pos[OFFSET_BITS-1:2];
    code_pos = pos - FOUR;
    hit3     = (hist[2] == 8'h01);
    hit4     = (hist[2] == 8'h00) && (hist[3] == 8'h01);
    hdr      = hit3 ? hist[3] : data_byte;
    kind     = hdr[KIND_W-1:0];
    code_ok  = win_ok && (code_pos >= earliest) && (hist[0] == 8'h00) &&
               (hist[1] == 8'h00) && (hit3 || hit4) && type_mask[kind];
    hdr_pos       = code_pos + (hit3 ? THREE : FOUR);
    earliest_next = code_pos + (hit3 ? FOUR : FIVE);
    close_size    = code_pos - open_offset;
    // A unit opened on the final byte spans up to the buffer end.
    end_size      = code_ok ? (hit3 ? TWO : ONE) : (pos + ONE - open_offset);

    rec.close_valid        = code_ok && unit_open;
    rec.close_res.offset   = RES_W'(open_offset);
    rec.close_res.size     = RES_W'(close_size);
    rec.close_res.kind     = open_kind;
    rec.close_res.found    = 1'b1;
    rec.close_res.last_nal = 1'b0;

    rec.end_valid        = end_of_buffer;
    rec.end_res.last_nal = 1'b1;
    if (code_ok || unit_open) begin
      rec.end_res.offset = RES_W'(code_ok ? hdr_pos : open_offset);
      rec.end_res.size   = RES_W'(end_size);
      rec.end_res.kind   = code_ok ? kind : open_kind;
      rec.end_res.found  = 1'b1;
    end else begin
      rec.end_res.offset = '0;
      rec.end_res.size   = '0;
      rec.end_res.kind   = '0;
      rec.end_res.found  = 1'b0;
    end

    rec_push = accept && (rec.close_valid || end_of_buffer);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_buffer)) begin
      for (int i = 0; i < 4; i++) begin
        hist[i] <= 8'hFF;
      end
      pos         <= '0;
      unit_open   <= 1'b0;
      open_offset <= '0;
      open_kind   <= '0;
      earliest    <= '0;
    end else if (accept) begin
      hist[0] <= hist[1];
      hist[1] <= hist[2];
      hist[2] <= hist[3];
      hist[3] <= data_byte;
      pos     <= pos + ONE;
      if (code_ok) begin
        unit_open   <= 1'b1;
        open_offset <= hdr_pos;
        open_kind   <= kind;
        earliest    <= earliest_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/nalsplit_fifo.sv =====
// Short record queue between the front end and the result sequencer.
// Depends on nalsplit_pkg.
`default_nettype none

module nalsplit_fifo import nalsplit_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  record_t   wr_data,
  input  wire logic rd_en,
  output record_t   rd_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  record_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nalsplit_back.sv =====
// Result sequencer: expands queued records into single result transactions.
// Depends on nalsplit_pkg.
`default_nettype none

module nalsplit_back import nalsplit_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  record_t   rec,
  input  wire logic rec_empty,
  output logic      rec_pop,
  input  wire logic pop,
  output logic      res_valid,
  output result_t   res
);

  logic    pend_valid;
  result_t pend;
  logic    load;

  // The output slot refills in the same cycle it is drained.
  assign load    = !res_valid || pop;
  assign rec_pop = load && !pend_valid && !rec_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        res_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!rec_empty) begin
        res_valid  <= 1'b1;
        pend_valid <= rec.close_valid && rec.end_valid;
      end else begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        res <= pend;
      end else if (!rec_empty) begin
        res  <= rec.close_valid ? rec.close_res : rec.end_res;
        pend <= rec.end_res;
      end
    end
  end

endmodule

`default_nettype wire
